@@ src/rsame_pkg.sv @@
// Shared types and constants for the RSA character modular exponentiation block.
// No dependencies; imported by rsa_char_modular_exponentiation.
`default_nettype none

package rsame_pkg;

  // Width of the modulus register as built by default.
  localparam int MODULUS_BITS_DEF = 31;
  // Fixed widths of the exponent registers, the input value and the result.
  localparam int EXP_BITS    = 31;
  localparam int VALUE_BITS  = 32;
  localparam int MAG_BITS    = 32;
  localparam int RESULT_BITS = 33;
  localparam int CFG_BITS    = 31;
  localparam int IDX_BITS    = 2;
  localparam int CNT_BITS    = $clog2(MAG_BITS + 1);

  // Offset between a lowercase character code and the plaintext digit.
  localparam logic [RESULT_BITS-1:0] CHAR_OFFSET = RESULT_BITS'(97);

  // Configuration register indexes.
  typedef enum logic [IDX_BITS-1:0] {
    REG_MODULUS     = 2'd0,
    REG_PUBLIC_EXP  = 2'd1,
    REG_PRIVATE_EXP = 2'd2,
    REG_UNUSED      = 2'd3
  } reg_idx_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED,
    ST_MUL,
    ST_SQR,
    ST_FIN
  } st_t;

endpackage

`default_nettype wire

@@ src/rsa_char_modular_exponentiation.sv @@
// Top level of the RSA character modular exponentiation block: config registers,
// square-and-multiply sequencer and a bit-serial modular multiplier. Uses rsame_pkg.
`default_nettype none

// Channel   Direction  Ports                           Transaction when
// input     in         in_valid in_stall in_mode       in_valid && !in_stall
//                      in_value
// result    out        out_valid out_stall out_result  out_valid && !out_stall
// config    in         cfg_we cfg_index cfg_data       cfg_we
//
// The modular multiplier consumes one bit of its multiplier operand per cycle and is
// shared by the initial reduction of the base, every square and every multiply; a zero
// exponent or a modulus below two skips it and goes straight to the final step.
// Reset is synchronous and active low; it restores the register defaults and empties
// the output register. A waiting result stalls only the final step, and a new input
// transaction is taken as soon as the sequencer is idle.

module rsa_char_modular_exponentiation
  import rsame_pkg::*;
#(
  parameter int MODULUS_BITS = MODULUS_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_mode,
  input  wire logic signed [VALUE_BITS-1:0] in_value,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [RESULT_BITS-1:0]     out_result,
  input  wire logic                         cfg_we,
  input  wire logic [IDX_BITS-1:0]          cfg_index,
  input  wire logic [CFG_BITS-1:0]          cfg_data
);

  localparam int W   = MODULUS_BITS;
  localparam int PAD = MAG_BITS - W;

  // Configuration registers.
  logic [W-1:0]        m_r, m_nxt;
  logic [EXP_BITS-1:0] e_pub_r, e_pub_nxt;
  logic [EXP_BITS-1:0] e_priv_r, e_priv_nxt;

  // Sequencer and datapath registers.
  st_t                 state_r, state_nxt;
  logic [EXP_BITS-1:0] ex_r, ex_nxt;
  logic [W-1:0]        acc_r, acc_nxt;
  logic [W-1:0]        b_r, b_nxt;
  logic [W-1:0]        p_r, p_nxt;
  logic [MAG_BITS-1:0] a_sr_r, a_sr_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                neg_r, neg_nxt;
  logic                dec_r, dec_nxt;

  // Output register.
  logic                   out_valid_r, out_valid_nxt;
  logic [RESULT_BITS-1:0] out_result_r, out_result_nxt;

  // Multiplier step: P <= (2P + bit * B) mod m, with 2P + B below 3m.
  logic         mul_bit;
  logic [W-1:0] mul_b;
  logic [W+1:0] mul_t;
  logic [W+2:0] mul_d1, mul_d2;
  logic [W-1:0] mul_res;
  logic         mul_last;

  // Input decoding.
  logic [RESULT_BITS-1:0] base;
  logic [RESULT_BITS-1:0] base_neg;
  logic [MAG_BITS-1:0]    mag;
  logic [EXP_BITS-1:0]    ex_sel;

  // Final result assembly.
  logic [RESULT_BITS-1:0] pow_u;
  logic [RESULT_BITS-1:0] pow_s;
  logic [RESULT_BITS-1:0] res_final;

  assign mul_bit  = a_sr_r[MAG_BITS-1];
  assign mul_b    = (state_r == ST_RED) ? W'(1) : b_r;
  assign mul_t    = {1'b0, p_r, 1'b0} + (mul_bit ? {2'b00, mul_b} : {(W+2){1'b0}});
  assign mul_d1   = {1'b0, mul_t} - {3'b000, m_r};
  assign mul_d2   = {1'b0, mul_t} - {2'b00, m_r, 1'b0};
  assign mul_res  = !mul_d2[W+2] ? mul_d2[W-1:0] :
                    !mul_d1[W+2] ? mul_d1[W-1:0] : mul_t[W-1:0];
  assign mul_last = (cnt_r == CNT_BITS'(1));

  // Encrypt removes the character offset first; the base is then split into sign
  // and magnitude so the power runs on the magnitude alone.
  assign base     = in_mode ? {in_value[VALUE_BITS-1], in_value}
                            : {in_value[VALUE_BITS-1], in_value} - CHAR_OFFSET;
  assign base_neg = -base;
  assign mag      = base[RESULT_BITS-1] ? base_neg[MAG_BITS-1:0] : base[MAG_BITS-1:0];
  assign ex_sel   = in_mode ? e_priv_r : e_pub_r;

  // The truncating remainder carries the sign of the power: negative only for an odd
  // exponent, a negative base and a nonzero reduced magnitude.
  assign pow_u     = RESULT_BITS'(acc_r);
  assign pow_s     = (neg_r && (acc_r != '0)) ? -pow_u : pow_u;
  assign res_final = dec_r ? pow_s + CHAR_OFFSET : pow_s;

  assign in_stall   = (state_r != ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

  always_comb begin
    m_nxt          = m_r;
    e_pub_nxt      = e_pub_r;
    e_priv_nxt     = e_priv_r;
    state_nxt      = state_r;
    ex_nxt         = ex_r;
    acc_nxt        = acc_r;
    b_nxt          = b_r;
    p_nxt          = p_r;
    a_sr_nxt       = a_sr_r;
    cnt_nxt        = cnt_r;
    neg_nxt        = neg_r;
    dec_nxt        = dec_r;
    out_valid_nxt  = out_valid_r;
    out_result_nxt = out_result_r;

    if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_MODULUS:     m_nxt      = cfg_data[W-1:0];
        REG_PUBLIC_EXP:  e_pub_nxt  = cfg_data[EXP_BITS-1:0];
        REG_PRIVATE_EXP: e_priv_nxt = cfg_data[EXP_BITS-1:0];
        default:         ;
      endcase
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          dec_nxt = in_mode;
          ex_nxt  = ex_sel;
          neg_nxt = base[RESULT_BITS-1] && ex_sel[0];
          if (ex_sel == '0) begin
            // A zero exponent gives one whatever the modulus.
            acc_nxt   = W'(1);
            neg_nxt   = 1'b0;
            state_nxt = ST_FIN;
          end else if (m_r <= W'(1)) begin
            // A modulus of zero or one reduces everything to zero.
            acc_nxt   = '0;
            state_nxt = ST_FIN;
          end else begin
            acc_nxt   = W'(1);
            p_nxt     = '0;
            a_sr_nxt  = mag;
            cnt_nxt   = CNT_BITS'(MAG_BITS);
            state_nxt = ST_RED;
          end
        end
      end

      ST_RED, ST_MUL, ST_SQR: begin
        p_nxt    = mul_res;
        a_sr_nxt = a_sr_r << 1;
        cnt_nxt  = cnt_r - CNT_BITS'(1);
        if (mul_last) begin
          p_nxt   = '0;
          cnt_nxt = CNT_BITS'(W);
          case (state_r)
            ST_RED: begin
              b_nxt = mul_res;
              if (ex_r[0]) begin
                a_sr_nxt  = {acc_r, {PAD{1'b0}}};
                state_nxt = ST_MUL;
              end else begin
                a_sr_nxt  = {mul_res, {PAD{1'b0}}};
                state_nxt = ST_SQR;
              end
            end
            ST_MUL: begin
              acc_nxt = mul_res;
              if (ex_r[EXP_BITS-1:1] == '0) begin
                state_nxt = ST_FIN;
              end else begin
                a_sr_nxt  = {b_r, {PAD{1'b0}}};
                state_nxt = ST_SQR;
              end
            end
            default: begin
              // Square done: move to the next exponent bit, which is known to exist.
              b_nxt  = mul_res;
              ex_nxt = ex_r >> 1;
              if (ex_r[1]) begin
                a_sr_nxt  = {acc_r, {PAD{1'b0}}};
                state_nxt = ST_MUL;
              end else begin
                a_sr_nxt  = {mul_res, {PAD{1'b0}}};
                state_nxt = ST_SQR;
              end
            end
          endcase
        end
      end

      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_result_nxt = res_final;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_r         <= W'(2);
      e_pub_r     <= '0;
      e_priv_r    <= '0;
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      m_r         <= m_nxt;
      e_pub_r     <= e_pub_nxt;
      e_priv_r    <= e_priv_nxt;
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ex_r         <= ex_nxt;
    acc_r        <= acc_nxt;
    b_r          <= b_nxt;
    p_r          <= p_nxt;
    a_sr_r       <= a_sr_nxt;
    cnt_r        <= cnt_nxt;
    neg_r        <= neg_nxt;
    dec_r        <= dec_nxt;
    out_result_r <= out_result_nxt;
  end

endmodule

`default_nettype wire
